>>> design/jict_pkg.sv
`default_nettype none
package jict_pkg;

	localparam int CHUNK_DEPTH = 64;
	localparam int WP_AW = $clog2(CHUNK_DEPTH);
	localparam int LEN_W = WP_AW + 1;
	localparam int MUL_AW = 33;
	localparam int MUL_BW = 32;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int DIV_NW = 53;
	localparam int DIV_DW = 20;
	localparam int TERM_W = MUL_PW - 15;
	localparam int QF_W = DIV_NW + 2;

	localparam logic [2:0] REG_STIFF = 3'd0;
	localparam logic [2:0] REG_DAMP = 3'd1;
	localparam logic [2:0] REG_GSMOOTH = 3'd2;
	localparam logic [2:0] REG_VSMOOTH = 3'd3;
	localparam logic [2:0] REG_PERIOD = 3'd4;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;
	localparam logic [1:0] REQ_ACTIVATE = 2'd3;

	localparam logic [1:0] RGN_NONE = 2'd0;
	localparam logic [1:0] RGN_BEFORE = 2'd1;
	localparam logic [1:0] RGN_INTERP = 2'd2;
	localparam logic [1:0] RGN_HOLD = 2'd3;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [31:0] TICKS_PER_SEC = 32'd1000000;

	function automatic logic [MUL_AW-1:0] mag33(input logic signed [MUL_AW-1:0] x);
		mag33 = x[MUL_AW-1] ? MUL_AW'(-x) : MUL_AW'(x);
	endfunction

	// floor(+-p / 65536)
	function automatic logic signed [TERM_W-1:0] q16_floor(input logic neg,
			input logic [MUL_PW-1:0] p);
		logic [MUL_PW-1:0] m;
		m = neg ? (p + MUL_PW'(65535)) >> 16 : p >> 16;
		q16_floor = neg ? -$signed(TERM_W'(m)) : $signed(TERM_W'(m));
	endfunction

	function automatic logic signed [QF_W-1:0] div_floor(input logic neg,
			input logic [DIV_NW-1:0] q, input logic nz);
		logic [QF_W-1:0] m;
		m = QF_W'(q) + QF_W'(neg & nz);
		div_floor = neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [16:0] clamp_w(input logic [16:0] w);
		clamp_w = (w > ONE_Q16) ? ONE_Q16 : w;
	endfunction

endpackage
`default_nettype wire

>>> design/joint_impedance_chunk_tracker_unit.sv
`default_nettype none
// a request transfer is taken while the unit is idle; waypoint, chunk and activate
// requests complete at the accepting edge, so the next one can be taken in the cycle after
// a control tick holds the input off until it loads the result register, using the
// shift-add multiplier and the divider for up to 10 passes after its transfer
// the next request is taken the cycle after; the load waits for a free output register
// arst_n clears control state and sets configuration to its defaults; the waypoint memory is not cleared
module joint_impedance_chunk_tracker_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// waypoint_index, waypoint_value, chunk_length, chunk_stamp, now_time,
	// joint_position, joint_velocity, zero fill
	input  wire logic [175:0] s_tdata,
	// req_type
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// torque
	output logic [31:0]       m_tdata,
	// torque_clipped, goal_region
	output logic [2:0]        m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata
);
	import jict_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_TICK = 5'd1;
	localparam logic [4:0] ST_ODIV = 5'd2;
	localparam logic [4:0] ST_RDA = 5'd3;
	localparam logic [4:0] ST_RDB = 5'd4;
	localparam logic [4:0] ST_RDC = 5'd5;
	localparam logic [4:0] ST_M1 = 5'd6;
	localparam logic [4:0] ST_D1 = 5'd7;
	localparam logic [4:0] ST_M2 = 5'd8;
	localparam logic [4:0] ST_D2 = 5'd9;
	localparam logic [4:0] ST_RDW = 5'd10;
	localparam logic [4:0] ST_SM = 5'd11;
	localparam logic [4:0] ST_SMW = 5'd12;
	localparam logic [4:0] ST_GK = 5'd13;
	localparam logic [4:0] ST_GKW = 5'd14;
	localparam logic [4:0] ST_GD = 5'd15;
	localparam logic [4:0] ST_GDW = 5'd16;
	localparam logic [4:0] ST_OUT = 5'd17;

	logic [31:0] stiff_q, damp_q;
	logic [16:0] gsm_q, vsm_q;
	logic [19:0] period_q;

	logic [4:0] state_q;
	logic chunk_valid_q, first_q;
	logic [31:0] start_time_q;
	logic [LEN_W-1:0] count_q;
	logic signed [31:0] last_raw_q, sgp_q, sgv_q, sv_q;
	logic signed [31:0] pos_q, vel_q, goal_q, gv_q, q0_q;
	logic [31:0] now_q;
	logic [1:0] region_q;
	logic [1:0] k_q;
	logic sgn_q;
	logic signed [32:0] d_q;
	logic [WP_AW-1:0] idx_q;
	logic [DIV_DW-1:0] r_q;
	logic signed [TERM_W-1:0] tk_q;

	logic [31:0] tdata_q;
	logic [2:0] tuser_q;
	logic mvalid_q;
	logic out_load;

	logic signed [31:0] wp_mem [CHUNK_DEPTH];
	logic signed [31:0] rd_q;
	logic [WP_AW-1:0] rd_addr;
	logic wr_en;

	logic accept;
	logic [1:0] req;
	logic [WP_AW-1:0] in_idx;
	logic signed [31:0] in_wval, in_pos, in_vel;
	logic [6:0] in_len;
	logic [LEN_W-1:0] len_sat;

	logic [31:0] diff;
	logic [LEN_W+DIV_DW-1:0] span;
	logic [WP_AW-1:0] end_slot;

	logic mul_start, div_start, mul_done, div_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_p;
	logic [DIV_NW-1:0] div_n, div_q;
	logic [DIV_DW-1:0] div_r;

	logic signed [32:0] d_new, sm_e;
	logic signed [31:0] sm_x, sm_s;
	logic [16:0] sm_w;
	logic signed [TERM_W-1:0] p_term;
	logic signed [31:0] sm_new;
	logic signed [QF_W-1:0] qf;
	logic signed [QF_W-1:0] goal_full;
	logic signed [32:0] ek, ed;
	logic signed [TERM_W:0] tsum;

	assign req = s_tuser;
	assign in_idx = s_tdata[WP_AW-1:0];
	assign in_wval = s_tdata[37:6];
	assign in_len = s_tdata[44:38];
	assign in_pos = s_tdata[140:109];
	assign in_vel = s_tdata[172:141];
	assign len_sat = (in_len > 7'(CHUNK_DEPTH)) ? LEN_W'(CHUNK_DEPTH) : LEN_W'(in_len);

	assign s_tready = state_q == ST_IDLE;
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = mvalid_q;
	assign m_tdata = tdata_q;
	assign m_tuser = tuser_q;
	assign out_load = state_q == ST_OUT && (!mvalid_q || m_tready);

	assign diff = now_q - start_time_q;
	assign end_slot = WP_AW'(count_q - LEN_W'(1));
	assign span = (LEN_W+DIV_DW)'(end_slot) * (LEN_W+DIV_DW)'(period_q);

	assign wr_en = accept && req == REQ_WRITE;

	always_comb begin
		case (state_q)
			ST_TICK: rd_addr = diff[31] ? '0 : end_slot;
			ST_RDA: rd_addr = idx_q;
			ST_RDB: rd_addr = WP_AW'(idx_q + WP_AW'(1));
			default: rd_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) wp_mem[in_idx] <= in_wval;
		rd_q <= wp_mem[rd_addr];
	end

	// smoothing operand selection
	always_comb begin
		case (k_q)
			2'd0: begin sm_x = goal_q; sm_s = sgp_q; sm_w = clamp_w(gsm_q); end
			2'd1: begin sm_x = gv_q; sm_s = sgv_q; sm_w = clamp_w(gsm_q); end
			default: begin sm_x = vel_q; sm_s = sv_q; sm_w = clamp_w(vsm_q); end
		endcase
	end

	assign d_new = 33'(rd_q) - 33'(q0_q);
	assign sm_e = 33'(sm_x) - 33'(sm_s);
	assign ek = 33'(sgp_q) - 33'(pos_q);
	assign ed = 33'(sgv_q) - 33'(sv_q);
	assign p_term = q16_floor(sgn_q, mul_p);
	assign sm_new = 32'(TERM_W'(sm_s) + p_term);
	assign qf = div_floor(sgn_q, div_q, div_r != '0);
	assign goal_full = QF_W'(q0_q) + qf;
	assign tsum = (TERM_W+1)'(tk_q) + (TERM_W+1)'(p_term);

	always_comb begin
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		div_n = DIV_NW'(diff);
		case (state_q)
			ST_TICK: div_start = chunk_valid_q && !diff[31] && period_q != '0 &&
				diff < 32'(span);
			ST_RDC: begin
				mul_start = 1'b1;
				mul_a = mag33(d_new);
				mul_b = MUL_BW'(r_q);
			end
			ST_M1, ST_M2: begin
				div_start = mul_done;
				div_n = mul_p[DIV_NW-1:0];
			end
			ST_D1: begin
				mul_start = div_done;
				mul_a = mag33(d_q);
				mul_b = TICKS_PER_SEC;
			end
			ST_SM: begin
				mul_start = !(first_q && k_q != 2'd2);
				mul_a = mag33(sm_e);
				mul_b = MUL_BW'(sm_w);
			end
			ST_GK: begin
				mul_start = 1'b1;
				mul_a = mag33(ek);
				mul_b = stiff_q;
			end
			ST_GD: begin
				mul_start = 1'b1;
				mul_a = mag33(ed);
				mul_b = damp_q;
			end
			default: ;
		endcase
	end

	jict_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	jict_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_n), .den(period_q),
		.done(div_done), .quo(div_q), .rem(div_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= '0;
			damp_q <= '0;
			gsm_q <= ONE_Q16;
			vsm_q <= 17'd6554;
			period_q <= 20'd20000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STIFF: stiff_q <= cfg_wdata;
				REG_DAMP: damp_q <= cfg_wdata;
				REG_GSMOOTH: gsm_q <= cfg_wdata[16:0];
				REG_VSMOOTH: vsm_q <= cfg_wdata[16:0];
				REG_PERIOD: period_q <= cfg_wdata[19:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_valid_q <= 1'b0;
			first_q <= 1'b1;
			start_time_q <= '0;
			count_q <= '0;
			last_raw_q <= '0;
			sgp_q <= '0;
			sgv_q <= '0;
			sv_q <= '0;
			mvalid_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (out_load) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req)
							REQ_START: begin
								start_time_q <= s_tdata[76:45];
								count_q <= len_sat;
								chunk_valid_q <= len_sat != '0;
							end
							REQ_ACTIVATE: begin
								sv_q <= '0;
								sgv_q <= '0;
								last_raw_q <= in_pos;
								sgp_q <= in_pos;
								first_q <= 1'b1;
							end
							REQ_TICK: state_q <= ST_TICK;
							default: ;
						endcase
					end
				end
				ST_TICK: begin
					k_q <= '0;
					if (!chunk_valid_q) state_q <= ST_SM;
					else if (div_start) state_q <= ST_ODIV;
					else state_q <= ST_RDW;
				end
				ST_ODIV: if (div_done) state_q <= ST_RDA;
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= ST_RDC;
				ST_RDC: state_q <= ST_M1;
				ST_M1: if (mul_done) state_q <= ST_D1;
				ST_D1: if (div_done) state_q <= ST_M2;
				ST_M2: if (mul_done) state_q <= ST_D2;
				ST_D2: if (div_done) state_q <= ST_SM;
				ST_RDW: state_q <= ST_SM;
				ST_SM: begin
					if (first_q && k_q != 2'd2) begin
						if (k_q == 2'd0) sgp_q <= goal_q;
						else sgv_q <= gv_q;
						k_q <= k_q + 2'd1;
					end else begin
						state_q <= ST_SMW;
					end
				end
				ST_SMW: begin
					if (mul_done) begin
						case (k_q)
							2'd0: sgp_q <= sm_new;
							2'd1: sgv_q <= sm_new;
							default: sv_q <= sm_new;
						endcase
						if (k_q == 2'd2) state_q <= ST_GK;
						else begin
							k_q <= k_q + 2'd1;
							state_q <= ST_SM;
						end
					end
				end
				ST_GK: begin
					first_q <= 1'b0;
					last_raw_q <= goal_q;
					state_q <= ST_GKW;
				end
				ST_GKW: if (mul_done) state_q <= ST_GD;
				ST_GD: state_q <= ST_GDW;
				ST_GDW: if (mul_done) state_q <= ST_OUT;
				ST_OUT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					now_q <= s_tdata[108:77];
					pos_q <= in_pos;
					vel_q <= in_vel;
				end
			end
			ST_TICK: begin
				goal_q <= last_raw_q;
				gv_q <= '0;
				if (!chunk_valid_q) region_q <= RGN_NONE;
				else if (diff[31]) region_q <= RGN_BEFORE;
				else if (div_start) region_q <= RGN_INTERP;
				else region_q <= RGN_HOLD;
			end
			ST_ODIV: begin
				idx_q <= div_q[WP_AW-1:0];
				r_q <= div_r;
			end
			ST_RDB: q0_q <= rd_q;
			ST_RDC: begin
				d_q <= d_new;
				sgn_q <= d_new[32];
			end
			ST_D1: if (div_done) goal_q <= goal_full[31:0];
			ST_D2: begin
				if (div_done) begin
					if (qf > QF_W'(32'sh7fffffff)) gv_q <= 32'sh7fffffff;
					else if (qf < -QF_W'(33'sh080000000)) gv_q <= 32'sh80000000;
					else gv_q <= qf[31:0];
				end
			end
			ST_RDW: goal_q <= rd_q;
			ST_SM: sgn_q <= sm_e[32];
			ST_GK: sgn_q <= ek[32];
			ST_GKW: if (mul_done) tk_q <= p_term;
			ST_GD: sgn_q <= ed[32];
			ST_GDW: tk_q <= tk_q;
			ST_OUT: begin
				if (out_load) begin
					if (tsum > (TERM_W+1)'(32'sh7fffffff)) begin
						tdata_q <= 32'h7fffffff;
						tuser_q <= {region_q, 1'b1};
					end else if (tsum < -(TERM_W+1)'(33'sh080000000)) begin
						tdata_q <= 32'h80000000;
						tuser_q <= {region_q, 1'b1};
					end else begin
						tdata_q <= tsum[31:0];
						tuser_q <= {region_q, 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	// the damping product must survive until ST_OUT: hold the multiplier idle
	// (it keeps its accumulator after done), so p_term there is D's term
endmodule
`default_nettype wire

>>> design/jict_mul.sv
`default_nettype none
module jict_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [jict_pkg::MUL_AW-1:0]   a,
	input  wire logic [jict_pkg::MUL_BW-1:0]   b,
	output logic                               done,
	output logic [jict_pkg::MUL_PW-1:0]        prod
);
	import jict_pkg::*;

	logic [MUL_PW-1:0] acc_q;
	logic [MUL_PW-1:0] a_q;
	logic [MUL_BW-1:0] b_q;
	logic [5:0] cnt_q;
	logic busy_q;

	assign done = busy_q && cnt_q == 6'd0;
	assign prod = acc_q;

	// shift-add, one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(MUL_BW);
		end else if (busy_q) begin
			if (cnt_q == 6'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= MUL_PW'(a);
			b_q <= b;
		end else if (busy_q && cnt_q != 6'd0) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end
endmodule
`default_nettype wire

>>> design/jict_div.sv
`default_nettype none
module jict_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [jict_pkg::DIV_NW-1:0]   num,
	input  wire logic [jict_pkg::DIV_DW-1:0]   den,
	output logic                               done,
	output logic [jict_pkg::DIV_NW-1:0]        quo,
	output logic [jict_pkg::DIV_DW-1:0]        rem
);
	import jict_pkg::*;

	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] r_q;
	logic [DIV_DW-1:0] d_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [DIV_DW:0] trial;

	assign done = busy_q && cnt_q == 6'd0;
	assign quo = n_q;
	assign rem = r_q;
	assign trial = {r_q, n_q[DIV_NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(DIV_NW);
		end else if (busy_q) begin
			if (cnt_q == 6'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 6'd1;
		end
	end

	// restoring division, quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q && cnt_q != 6'd0) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= DIV_DW'(trial - {1'b0, d_q});
				n_q <= {n_q[DIV_NW-2:0], 1'b1};
			end else begin
				r_q <= trial[DIV_DW-1:0];
				n_q <= {n_q[DIV_NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import jict_pkg::*;

	typedef struct packed {
		logic signed [31:0] torque;
		logic               clipped;
		logic [1:0]         region;
	} torque_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [175:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_wdata = '0;

	joint_impedance_chunk_tracker_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// shadow of the controller state
	logic [31:0]        k_gain = 0, d_gain = 0;
	logic [16:0]        goal_w = 17'd65536, vel_w = 17'd6554;
	logic [19:0]        wp_period = 20'd20000;
	logic signed [31:0] wp_mem [CHUNK_DEPTH];
	logic               chunk_on = 0;
	logic [31:0]        chunk_t0 = 0;
	logic [6:0]         chunk_len = 0;
	logic               first_tick = 1;
	logic signed [31:0] raw_goal_hold = 0, goal_pos_f = 0, goal_vel_f = 0, vel_f = 0;

	torque_result_t torque_q [$];
	int  errors = 0;
	int  send_idle = 0, recv_idle = 0;
	int  hold_left = 0;
	logic [31:0] cur_stamp = 0;
	int  cur_len = 1;

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	function automatic logic signed [31:0] smooth(logic signed [31:0] s,
			logic signed [31:0] x, logic [16:0] w);
		longint dl, wl;
		dl = longint'(x) - longint'(s);
		wl = (w > 17'd65536) ? 65536 : longint'(w);
		return 32'(longint'(s) + floor_div(dl * wl, 65536));
	endfunction

	function automatic longint gain_term(logic [31:0] g, longint e);
		logic [65:0] mag;
		mag = 66'(e < 0 ? -e : e) * 66'(g);
		if (e < 0)
			return -longint'((mag + 66'd65535) >> 16);
		return longint'(mag >> 16);
	endfunction

	function automatic torque_result_t predict_tick(logic [31:0] now_t,
			logic signed [31:0] pos, logic signed [31:0] vel);
		torque_result_t res;
		logic signed [31:0] goal, goal_v;
		logic [31:0] diff, idx, rem;
		longint span, dd, tq, gv;
		goal = raw_goal_hold;
		goal_v = 0;
		res.region = RGN_NONE;
		if (chunk_on) begin
			diff = now_t - chunk_t0;
			span = longint'(chunk_len - 1) * longint'(wp_period);
			if (diff[31]) begin
				res.region = RGN_BEFORE;
				goal = wp_mem[0];
			end else if (longint'(diff) >= span || wp_period == 0) begin
				res.region = RGN_HOLD;
				goal = wp_mem[chunk_len - 1];
			end else begin
				idx = diff / wp_period;
				rem = diff - idx * wp_period;
				dd = longint'(wp_mem[idx + 1]) - longint'(wp_mem[idx]);
				res.region = RGN_INTERP;
				goal = 32'(longint'(wp_mem[idx]) + floor_div(dd * longint'(rem),
					longint'(wp_period)));
				gv = floor_div(dd * 1000000, longint'(wp_period));
				if (gv > 64'sd2147483647) gv = 64'sd2147483647;
				if (gv < -64'sd2147483648) gv = -64'sd2147483648;
				goal_v = 32'(gv);
			end
		end
		if (first_tick) begin
			goal_pos_f = goal;
			goal_vel_f = goal_v;
			first_tick = 0;
		end else begin
			goal_pos_f = smooth(goal_pos_f, goal, goal_w);
			goal_vel_f = smooth(goal_vel_f, goal_v, goal_w);
		end
		raw_goal_hold = goal;
		vel_f = smooth(vel_f, vel, vel_w);
		tq = gain_term(k_gain, longint'(goal_pos_f) - longint'(pos)) +
			gain_term(d_gain, longint'(goal_vel_f) - longint'(vel_f));
		res.clipped = 0;
		if (tq > 64'sd2147483647) begin
			tq = 64'sd2147483647;
			res.clipped = 1;
		end else if (tq < -64'sd2147483648) begin
			tq = -64'sd2147483648;
			res.clipped = 1;
		end
		res.torque = 32'(tq);
		return res;
	endfunction

	// one request transfer; state is updated when the transfer is accepted
	task automatic send_item(logic [1:0] req, logic [31:0] wi, logic [31:0] wv,
			logic [31:0] len, logic [31:0] stamp, logic [31:0] now_t,
			logic [31:0] pos, logic [31:0] vel);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tuser = req;
		s_tdata = {3'b0, vel, pos, now_t, stamp, len[6:0], wv, wi[5:0]};
		do @(posedge clk); while (!s_tready);
		case (req)
			REQ_WRITE: wp_mem[wi[5:0]] = wv;
			REQ_START: begin
				chunk_t0 = stamp;
				chunk_len = (len[6:0] > 7'd64) ? 7'd64 : len[6:0];
				chunk_on = (len[6:0] != 7'd0);
			end
			REQ_ACTIVATE: begin
				vel_f = 0;
				goal_vel_f = 0;
				raw_goal_hold = pos;
				goal_pos_f = pos;
				first_tick = 1;
			end
			default: torque_q.insert(torque_q.size(), predict_tick(now_t, pos, vel));
		endcase
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic wait_drained();
		while (torque_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			REG_STIFF: k_gain = val;
			REG_DAMP: d_gain = val;
			REG_GSMOOTH: goal_w = val[16:0];
			REG_VSMOOTH: vel_w = val[16:0];
			REG_PERIOD: wp_period = val[19:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic set_regs(logic [31:0] k, logic [31:0] d, logic [31:0] gw,
			logic [31:0] vw, logic [31:0] per);
		wait_drained();
		write_reg(REG_STIFF, k);
		write_reg(REG_DAMP, d);
		write_reg(REG_GSMOOTH, gw);
		write_reg(REG_VSMOOTH, vw);
		write_reg(REG_PERIOD, per);
	endtask

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(3))
			0: return $urandom;
			default: return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
		endcase
	endfunction

	task automatic tick_at(logic [31:0] now_t);
		send_item(REQ_TICK, $urandom, $urandom, $urandom, $urandom, now_t,
			rand_q16(), rand_q16());
	endtask

	task automatic random_item();
		int r;
		logic [31:0] span;
		r = $urandom_range(99);
		span = cur_len * wp_period;
		if (r < 8) begin
			send_item(REQ_WRITE, $urandom, rand_q16(), $urandom, $urandom, $urandom,
				$urandom, $urandom);
		end else if (r < 12) begin
			cur_stamp = $urandom;
			case ($urandom_range(9))
				0: cur_len = 0;
				1: cur_len = $urandom_range(65, 127);
				default: cur_len = $urandom_range(1, 64);
			endcase
			send_item(REQ_START, $urandom, $urandom, 32'(cur_len), cur_stamp, $urandom,
				$urandom, $urandom);
			if (cur_len > 64) cur_len = 64;
		end else if (r < 15) begin
			send_item(REQ_ACTIVATE, $urandom, $urandom, $urandom, $urandom, $urandom,
				rand_q16(), $urandom);
		end else if (r < 23) begin
			tick_at(cur_stamp - $urandom_range(1, 100000));
		end else if (r < 27) begin
			tick_at($urandom);
		end else begin
			tick_at(cur_stamp + $urandom_range(0, span + wp_period));
		end
	endtask

	task automatic test_reset_and_regs();
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// ticks with reset settings and no chunk
		tick_at(0);
		tick_at(32'hFFFF_FFFF);
		set_regs(32'h0001_0000, 32'h0000_0800, 32'd65536, 32'd6554, 32'd20000);
		for (int i = 0; i < CHUNK_DEPTH; i++)
			send_item(REQ_WRITE, 32'(i), 32'($signed(i * 1000) - 30000), 0, 0, 0, 0, 0);
	endtask

	task automatic test_directed();
		send_item(REQ_WRITE, 32'd0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
		send_item(REQ_WRITE, 32'd1, 32'h8000_0000, 0, 0, 0, 0, 0);
		send_item(REQ_WRITE, 32'd63, 32'h0000_0000, 0, 0, 0, 0, 0);
		send_item(REQ_ACTIVATE, 0, 0, 0, 0, 0, 32'h0001_0000, 0);
		send_item(REQ_START, 0, 0, 32'd0, 32'd100, 0, 0, 0);
		tick_at(32'd200);
		// chunk longer than the store
		send_item(REQ_START, 0, 0, 32'd127, 32'd1000, 0, 0, 0);
		tick_at(32'd999);
		tick_at(32'd1000);
		tick_at(32'd11000);
		tick_at(32'd1000 + 63 * 20000);
		tick_at(32'd1000 + 32'h8000_0000);
		send_item(REQ_TICK, 0, 0, 0, 0, 32'd25000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(REQ_TICK, 0, 0, 0, 0, 32'd26000, 32'h8000_0000, 32'h7FFF_FFFF);
		set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd131071, 32'd0);
		tick_at(32'd5000);
		tick_at(32'd0);
		send_item(REQ_TICK, 0, 0, 0, 0, 32'd5000, 32'h8000_0000, 32'h8000_0000);
		set_regs(32'd0, 32'h0000_0001, 32'd131071, 32'd0, 32'h000F_FFFF);
		send_item(REQ_START, 0, 0, 32'd2, 32'hFFFF_FF00, 0, 0, 0);
		tick_at(32'd1000);
		tick_at(32'hFFFF_FFFF);
		send_item(REQ_START, 0, 0, 32'd1, 32'd0, 0, 0, 0);
		tick_at(32'd0);
	endtask

	task automatic test_random(int n, int s_idle, int r_idle);
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int i = 0; i < n; i++)
			random_item();
	endtask

	task automatic test_backpressure();
		send_idle = 0;
		hold_left = 4000;
		for (int i = 0; i < 12; i++)
			tick_at(cur_stamp + $urandom_range(0, 200000));
		wait_drained();
		for (int i = 0; i < 8; i++)
			random_item();
	endtask

	// receiver side: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 0;
			hold_left--;
		end else begin
			m_tready = ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		torque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (torque_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer torque=%h user=%h", $time, m_tdata, m_tuser);
			end else begin
				want = torque_q.pop_front();
				if (m_tdata !== want.torque) begin
					errors++;
					$display("%0t: torque expected %h actual %h", $time, want.torque, m_tdata);
				end
				if (m_tuser[0] !== want.clipped) begin
					errors++;
					$display("%0t: clipped expected %b actual %b", $time, want.clipped, m_tuser[0]);
				end
				if (m_tuser[2:1] !== want.region) begin
					errors++;
					$display("%0t: region expected %0d actual %0d", $time, want.region,
						m_tuser[2:1]);
				end
			end
		end
	end

	initial begin
		test_reset_and_regs();
		test_directed();
		set_regs(32'h0002_0000, 32'h0000_1000, 32'd16384, 32'd6554, 32'd20000);
		cur_len = 8;
		test_random(500, 25, 65);
		test_backpressure();
		set_regs($urandom, $urandom, $urandom_range(0, 131071), $urandom_range(0, 131071),
			$urandom_range(1, 1048575));
		test_random(500, 65, 25);
		set_regs(32'h0000_8000, 32'h0000_0100, 32'd65536, 32'd65536, 32'd1);
		test_random(500, 0, 0);
		wait_drained();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
